// ===== src/dcc_pkg.sv =====
// Package for the distinct column counter: sizes, register indexes,
// the configuration and slot structs, and the count clamp function.
// Used by every module of the block; depends on nothing.
package dcc_pkg;

	localparam int MAX_ROWS    = 16;
	localparam int MAX_COLUMNS = 16;

	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;
	localparam int TALLY_W = 5;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	typedef enum logic {
		REG_ROW_COUNT    = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} reg_index_t;

	// Clamped last row and column index, plus a pulse on any register write.
	typedef struct packed {
		logic [ROW_W-1:0] row_last;
		logic [COL_W-1:0] col_last;
		logic             restart;
	} cfg_t;

	// Position of the element held in the input stage.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             row_end;
		logic             col_end;
	} slot_t;

	// A count of zero acts as one, and a count above the maximum acts as the maximum.
	function automatic int clamp_last(logic [COUNT_W-1:0] v, int max_count);
		int n;
		n = int'(v);
		if (n < 1) n = 1;
		if (n > max_count) n = max_count;
		return n - 1;
	endfunction

endpackage

// ===== src/dcc_cfg_regs.sv =====
// Configuration registers of the distinct column counter behind an APB-style port.
// Depends on dcc_pkg for register indexes, widths and the clamp function.
module dcc_cfg_regs import dcc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [COUNT_W-1:0] row_count_q;
	logic [COUNT_W-1:0] column_count_q;
	logic               wr_en;
	reg_index_t         index;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign index  = reg_index_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= COUNT_W'(1);
			column_count_q <= COUNT_W'(1);
		end else if (wr_en) begin
			case (index)
				REG_ROW_COUNT:    row_count_q    <= pwdata[COUNT_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_ROW_COUNT:    prdata = DATA_W'(row_count_q);
			REG_COLUMN_COUNT: prdata = DATA_W'(column_count_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.row_last = ROW_W'(clamp_last(row_count_q, MAX_ROWS));
	assign cfg.col_last = COL_W'(clamp_last(column_count_q, MAX_COLUMNS));
	// Every write restarts the matrix; the address decode covers only real registers.
	assign cfg.restart  = wr_en;

endmodule

// ===== src/dcc_col_bank.sv =====
// Element storage for one matrix column, one word per row, with a registered
// read port that forwards a same-cycle write. Depends on dcc_pkg for sizes.
module dcc_col_bank import dcc_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [ROW_W-1:0]   waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [ROW_W-1:0]   raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [MAX_ROWS];
	logic [VALUE_W-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			if (we && waddr == raddr) begin
				rdata_s1 <= wdata;
			end else begin
				rdata_s1 <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_s1;

endmodule

// ===== src/dcc_front.sv =====
// Input side of the distinct column counter: row and column position counters
// and the input stage register. Depends on dcc_pkg for the structs.
module dcc_front import dcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	input  logic [VALUE_W-1:0] element_value,
	input  logic               advance,
	output logic               in_stall,
	output logic               accept,
	output logic [ROW_W-1:0]   read_row,
	output logic               valid_s1,
	output slot_t              item_s1,
	output logic [VALUE_W-1:0] value_s1
);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             row_end;
	logic             col_end;

	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign read_row = row_q;
	assign row_end  = (row_q == cfg.row_last);
	assign col_end  = (col_q == cfg.col_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg.restart) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (!row_end) begin
					row_q <= row_q + ROW_W'(1);
				end else begin
					row_q <= '0;
					col_q <= col_end ? '0 : col_q + COL_W'(1);
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.row     <= row_q;
			item_s1.col     <= col_q;
			item_s1.row_end <= row_end;
			item_s1.col_end <= col_end;
			value_s1        <= element_value;
		end
	end

endmodule

// ===== src/dcc_tally.sv =====
// Match flags, unique column tally and result register of the distinct
// column counter. Depends on dcc_pkg for sizes and the slot struct.
module dcc_tally import dcc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   restart,
	input  logic                   valid_s1,
	input  slot_t                  item_s1,
	input  logic [MAX_COLUMNS-1:0] equal,
	input  logic                   out_stall,
	output logic                   advance,
	output logic                   fire,
	output logic                   out_valid,
	output logic [TALLY_W-1:0]     unique_columns
);

	logic [MAX_COLUMNS-1:0] flags_q;
	logic [MAX_COLUMNS-1:0] below;
	logic [MAX_COLUMNS-1:0] base;
	logic [MAX_COLUMNS-1:0] flags_next;
	logic [TALLY_W-1:0]     tally_q;
	logic [TALLY_W-1:0]     tally_next;
	logic                   last;
	logic                   is_unique;
	logic                   out_valid_q;
	logic [TALLY_W-1:0]     unique_columns_q;

	assign last    = item_s1.row_end && item_s1.col_end;
	// Only the matrix's final element needs room in the result register.
	assign advance = !(last && out_valid_q && out_stall);
	assign fire    = valid_s1 && advance;

	always_comb begin
		for (int k = 0; k < MAX_COLUMNS; k++) begin
			below[k] = (k < int'(item_s1.col));
		end
	end

	// A new column starts with every earlier column as a candidate match.
	assign base       = (item_s1.row == '0) ? below : flags_q;
	assign flags_next = base & equal;
	assign is_unique  = (item_s1.col == '0) || (flags_next == '0);
	assign tally_next = tally_q + TALLY_W'(item_s1.row_end && is_unique);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (restart) begin
				flags_q <= '0;
				tally_q <= '0;
			end else if (fire) begin
				flags_q <= last ? '0 : flags_next;
				tally_q <= last ? '0 : tally_next;
			end
			if (fire && last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last) begin
			unique_columns_q <= tally_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign unique_columns = unique_columns_q;

endmodule

// ===== src/distinct_column_counter.sv =====
// Distinct column counter: one matrix element per beat, column-major order.
// Throughput is one element per cycle; the only hold-up is a result still waiting.
// The result path runs through the input stage register and then the result register: out_valid
// rises once the last element fires from the input stage (the column banks are read at the accepting edge).
// Reset clears positions, flags, tally and valids and sets both counts to 1;
// the column banks need no clearing, since entries are read only after a write.
module distinct_column_counter import dcc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] element_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [TALLY_W-1:0]        unique_columns,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready
);

	cfg_t                   cfg;
	slot_t                  item_s1;
	logic                   valid_s1;
	logic [VALUE_W-1:0]     value_s1;
	logic                   accept;
	logic                   advance;
	logic                   fire;
	logic [ROW_W-1:0]       read_row;
	logic [MAX_COLUMNS-1:0] equal;
	logic [VALUE_W-1:0]     bank_data [MAX_COLUMNS];

	dcc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dcc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.element_value (element_value),
		.advance       (advance),
		.in_stall      (in_stall),
		.accept        (accept),
		.read_row      (read_row),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.value_s1      (value_s1)
	);

	// Each bank is read at the incoming element's row, so every earlier column
	// of that row is ready for comparison in the input stage.
	for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_col
		dcc_col_bank u_bank (
			.clk   (clk),
			.we    (fire && item_s1.col == COL_W'(k)),
			.waddr (item_s1.row),
			.wdata (value_s1),
			.re    (accept),
			.raddr (read_row),
			.rdata (bank_data[k])
		);
		assign equal[k] = (bank_data[k] == value_s1);
	end

	dcc_tally u_tally (
		.clk            (clk),
		.arst_n         (arst_n),
		.restart        (cfg.restart),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1),
		.equal          (equal),
		.out_stall      (out_stall),
		.advance        (advance),
		.fire           (fire),
		.out_valid      (out_valid),
		.unique_columns (unique_columns)
	);

endmodule

// ===== src/dcc_checker.sv =====
// Port-level checks for the distinct column counter, bound to its top level.
// Depends on dcc_pkg for port widths.
module dcc_checker import dcc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [TALLY_W-1:0] unique_columns
);

	// A held result beat keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(unique_columns))
		else $error("result beat changed while stalled");

	// Column 0 is always unique, so a count is never zero.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unique_columns != '0)
		else $error("result count of zero");

	// The input side backs up only behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled with the result side free");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind distinct_column_counter dcc_checker u_dcc_checker (.*);

// ===== tb/tb_distinct_column_counter.sv =====
// Testbench for distinct_column_counter: directed and random matrices, random idling on
// both channels and APB count writes, each result checked against an in-bench predictor.
// Depends on dcc_pkg and distinct_column_counter only.
module tb_distinct_column_counter;
	import dcc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 400;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [VALUE_W-1:0] element_value;
	logic                      out_valid;
	logic                      out_stall;
	logic [TALLY_W-1:0]        unique_columns;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [ADDR_W-1:0]         paddr;
	logic [DATA_W-1:0]         pwdata;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;

	// Predictor state: stored elements, per-column match flags, positions and counts.
	logic [VALUE_W-1:0]     seen_elements [MAX_COLUMNS][MAX_ROWS];
	logic [MAX_COLUMNS-1:0] still_equal;
	int                     cur_row;
	int                     cur_col;
	logic [TALLY_W-1:0]     tally;
	logic [COUNT_W-1:0]     rows_reg;
	logic [COUNT_W-1:0]     cols_reg;

	logic [TALLY_W-1:0] expected_counts [$];
	int                 failures;
	int                 idle_cycles;
	int                 hold_cycles;
	bit                 no_idle;
	int                 random_items;

	distinct_column_counter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.unique_columns(unique_columns),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int effective_count(logic [COUNT_W-1:0] v, int ceiling);
		if (v == '0) return 1;
		if (int'(v) > ceiling) return ceiling;
		return int'(v);
	endfunction

	function automatic void restart_matrix();
		still_equal = '0;
		cur_row = 0;
		cur_col = 0;
		tally = '0;
	endfunction

	// Advances the predictor by one element; returns 1 when the matrix is complete.
	function automatic bit count_distinct_step(input logic [VALUE_W-1:0] v,
			output logic [TALLY_W-1:0] count);
		int rows;
		int cols;
		rows = effective_count(rows_reg, MAX_ROWS);
		cols = effective_count(cols_reg, MAX_COLUMNS);
		count = '0;
		if (cur_row >= rows || cur_col >= cols) restart_matrix();
		if (cur_row == 0) begin
			still_equal = '0;
			for (int k = 0; k < cur_col; k++) still_equal[k] = 1'b1;
		end
		for (int k = 0; k < cur_col; k++) begin
			if (seen_elements[k][cur_row] != v) still_equal[k] = 1'b0;
		end
		seen_elements[cur_col][cur_row] = v;
		if (cur_row + 1 < rows) begin
			cur_row++;
			return 1'b0;
		end
		if (cur_col == 0 || still_equal == '0) tally++;
		cur_row = 0;
		if (cur_col + 1 < cols) begin
			cur_col++;
			return 1'b0;
		end
		count = tally;
		restart_matrix();
		return 1'b1;
	endfunction

	// Everything is sampled at the rising edge, before the block's own updates land.
	always @(posedge clk) begin : beat_monitor
		logic [TALLY_W-1:0] want;
		logic [TALLY_W-1:0] next_count;
		bit                 moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_counts.size() == 0) begin
					$error("unique_columns: no result expected, got %0d", unique_columns);
					failures++;
				end else begin
					want = expected_counts.pop_front();
					if (unique_columns !== want) begin
						$error("unique_columns: expected %0d, got %0d", want, unique_columns);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				if (count_distinct_step(element_value, next_count))
					expected_counts.push_back(next_count);
			end
			if (psel && penable && pwrite && pready) begin
				moved = 1'b1;
				if (paddr[ADDR_W-1:2] == REG_ROW_COUNT) begin
					rows_reg = pwdata[COUNT_W-1:0];
				end else begin
					cols_reg = pwdata[COUNT_W-1:0];
				end
				restart_matrix();
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// Result side: a random stall before each beat, or a long hold-off when one is requested.
	initial begin : result_sink
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 10);
			end
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat, valid still high.
	task automatic send_element(input logic [VALUE_W-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		element_value = v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		in_valid = 1'b0;
		while (expected_counts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input reg_index_t idx, input logic [DATA_W-1:0] value);
		in_valid = 1'b0;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return VALUE_W'($urandom_range(0, 3));
			4: return $urandom;
			5: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0000;
				endcase
			end
			6: return 32'hFFFF_FFFF - VALUE_W'($urandom_range(0, 3));
			default: return $urandom ^ (32'h1 << $urandom_range(0, 31));
		endcase
	endfunction

	// Columns are often copies of earlier ones, or copies with a single bit flipped.
	task automatic send_random_matrix();
		logic [VALUE_W-1:0] m [MAX_COLUMNS][MAX_ROWS];
		int rows;
		int cols;
		int src;
		int pick;
		rows = effective_count(rows_reg, MAX_ROWS);
		cols = effective_count(cols_reg, MAX_COLUMNS);
		for (int c = 0; c < cols; c++) begin
			pick = $urandom_range(0, 7);
			if (c > 0 && pick < 5) begin
				src = $urandom_range(0, c - 1);
				for (int r = 0; r < rows; r++) m[c][r] = m[src][r];
				if (pick >= 3)
					m[c][$urandom_range(0, rows - 1)] ^= 32'h1 << $urandom_range(0, 31);
			end else begin
				for (int r = 0; r < rows; r++) m[c][r] = pick_value();
			end
		end
		for (int c = 0; c < cols; c++) begin
			for (int r = 0; r < rows; r++) begin
				send_element(m[c][r]);
				random_items++;
			end
		end
	endtask

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COUNT_W'(16);
			2: return COUNT_W'($urandom_range(17, 31));
			3: return COUNT_W'($urandom_range(6, 15));
			default: return COUNT_W'($urandom_range(1, 5));
		endcase
	endfunction

	task automatic test_default_counts();
		// After reset both counts are one, so every element is a whole matrix.
		send_element(32'h8000_0000);
		send_element(32'h7FFF_FFFF);
		wait_results_drained();
	endtask

	task automatic test_count_clamping();
		// Zero rows act as one; 31 columns act as the maximum of 16.
		write_register(REG_ROW_COUNT, 32'd0);
		write_register(REG_COLUMN_COUNT, 32'd31);
		for (int c = 0; c < 16; c++)
			send_element(32'h8000_0000 + VALUE_W'(c % 8));
		wait_results_drained();
		write_register(REG_COLUMN_COUNT, 32'd0);
		send_element(32'hFFFF_FFFF);
		wait_results_drained();
	endtask

	task automatic test_restart_on_write();
		write_register(REG_ROW_COUNT, 32'd2);
		write_register(REG_COLUMN_COUNT, 32'd2);
		send_element(32'h1111_1111);
		send_element(32'h2222_2222);
		send_element(32'h3333_3333);
		wait_results_drained();
		// A write in the middle of a matrix drops the partial one.
		write_register(REG_COLUMN_COUNT, 32'hFFFF_FFE2);
		send_element(32'h0000_0005);
		send_element(32'h8000_0000);
		send_element(32'h0000_0005);
		send_element(32'h8000_0000);
		wait_results_drained();
	endtask

	task automatic test_backpressure();
		write_register(REG_ROW_COUNT, 32'd1);
		write_register(REG_COLUMN_COUNT, 32'd1);
		no_idle = 1'b1;
		hold_cycles = 80;
		for (int i = 0; i < 24; i++) send_element(pick_value());
		no_idle = 1'b0;
		wait_results_drained();
		for (int i = 0; i < 6; i++) send_element(pick_value());
		wait_results_drained();
	endtask

	task automatic test_random_matrices();
		int matrices;
		matrices = 0;
		random_items = 0;
		wait_results_drained();
		write_register(REG_ROW_COUNT, {27'($urandom_range(0, 1 << 26)), 5'd31});
		write_register(REG_COLUMN_COUNT, 32'd3);
		while (random_items < RANDOM_ITEMS) begin
			if (matrices % 6 == 5) begin
				wait_results_drained();
				rows_pick_and_write();
			end else if ($urandom_range(0, 4) == 0) begin
				wait_results_drained();
			end
			no_idle = ($urandom_range(0, 3) == 0);
			send_random_matrix();
			matrices++;
		end
		no_idle = 1'b0;
	endtask

	// Keeps most matrices small: large row counts go with few columns and the reverse.
	task automatic rows_pick_and_write();
		logic [COUNT_W-1:0] r;
		logic [COUNT_W-1:0] c;
		r = pick_count();
		c = pick_count();
		if (effective_count(r, MAX_ROWS) * effective_count(c, MAX_COLUMNS) > 64)
			c = COUNT_W'($urandom_range(1, 4));
		write_register(REG_ROW_COUNT, {27'($urandom), r});
		write_register(REG_COLUMN_COUNT, {27'($urandom), c});
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		element_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		failures = 0;
		hold_cycles = 0;
		no_idle = 1'b0;
		rows_reg = COUNT_W'(1);
		cols_reg = COUNT_W'(1);
		restart_matrix();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_default_counts();
		test_count_clamping();
		test_restart_on_write();
		test_backpressure();
		test_random_matrices();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_counts.size() != 0) begin
			$error("unique_columns: %0d results never arrived", expected_counts.size());
			failures++;
		end
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/dcc_pkg.sv
src/dcc_cfg_regs.sv
src/dcc_col_bank.sv
src/dcc_front.sv
src/dcc_tally.sv
src/distinct_column_counter.sv
src/dcc_checker.sv
tb/tb_distinct_column_counter.sv
